// File: rtl/core/bracketed_root_finder_assert.svh
// Assertion macros used by the checker file.
`ifndef BRACKETED_ROOT_FINDER_ASSERT_SVH
`define BRACKETED_ROOT_FINDER_ASSERT_SVH

// Check that cond holds whenever trig holds, in the same cycle.
`define BRF_ASSERT_SAME(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");

// Check that cond holds in the cycle after trig.
`define BRF_ASSERT_NEXT(label, clk, rst, trig, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");

`endif

// File: rtl/core/brf_pkg.sv
`default_nettype none
package brf_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int IO_WIDTH        = 32;
   localparam int ABS_TOL_WIDTH   = 31;
   localparam int REL_TOL_WIDTH   = 16;
   localparam int TOL_SHIFT       = 16;

   typedef enum logic [1:0] {
      KIND_EVAL = 2'd0,
      KIND_DONE = 2'd1,
      KIND_IDLE = 2'd2
   } brf_kind_type;

   typedef enum logic {
      CSR_ABS_TOL = 1'b0,
      CSR_REL_TOL = 1'b1
   } brf_csr_type;

   typedef enum logic [1:0] {
      OP_MUL    = 2'd0,
      OP_TOLMUL = 2'd1,
      OP_DIV    = 2'd2
   } brf_op_type;

   typedef enum logic [1:0] {
      AS_IDLE = 2'd0,
      AS_MUL  = 2'd1,
      AS_DIV  = 2'd2,
      AS_SAT  = 2'd3
   } brf_alu_state_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_WAIT_FIRST, ST_WAIT_SECOND, ST_WAIT_PROBE,
      ST_SWAP, ST_TOL_GO, ST_TOL_WAIT, ST_TEST,
      ST_P_GO, ST_P_WAIT, ST_FDB_GO, ST_FDB_WAIT, ST_FDA_GO, ST_FDA_WAIT,
      ST_PF_GO, ST_PF_WAIT, ST_T1_GO, ST_T1_WAIT, ST_T2_GO, ST_T2_WAIT,
      ST_SIGN, ST_QT_GO, ST_QT_WAIT, ST_MQ_GO, ST_MQ_WAIT,
      ST_DIV_GO, ST_DIV_WAIT, ST_UPDATE
   } brf_state_type;

endpackage
`default_nettype wire

// File: rtl/core/brf_alu.sv
`default_nettype none
// Shared iterative unit: shift-add multiply and restoring divide on
// magnitudes, with a final saturating step back to a signed value.
module brf_alu #(
   parameter int VALUE_WIDTH = brf_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = brf_pkg::FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire brf_pkg::brf_op_type           op,
   input  wire logic signed [VALUE_WIDTH-1:0] opa,
   input  wire logic signed [VALUE_WIDTH-1:0] opb,
   output logic                               done,
   output logic signed [VALUE_WIDTH-1:0]      result
);

   localparam int W  = VALUE_WIDTH;
   localparam int NW = VALUE_WIDTH + FRAC_BITS;
   localparam int SW = (2 * W > NW) ? 2 * W : NW;
   localparam int CW = $clog2(NW + 1);
   localparam logic [SW-1:0] POS_LIM = SW'({1'b0, {(W-1){1'b1}}});
   localparam logic [SW-1:0] NEG_LIM = SW'({1'b1, {(W-1){1'b0}}});

   function automatic logic [W-1:0] magf(input logic signed [W-1:0] x);
      return x[W-1] ? W'(-x) : W'(x);
   endfunction

   brf_pkg::brf_alu_state_type state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic [2*W:0]    prod_ff, prod_in;
   logic [W-1:0]    mcand_ff, mcand_in;
   logic [W:0]      rem_ff, rem_in;
   logic [NW-1:0]   num_ff, num_in;
   logic [W-1:0]    dvsr_ff, dvsr_in;
   logic            neg_ff, neg_in;
   logic            tol_ff, tol_in;
   logic            div_ff, div_in;
   logic            done_ff, done_in;
   logic signed [W-1:0] res_ff, res_in;

   logic [W-1:0]  ma, mb;
   logic [W:0]    sum, r2;
   logic [SW-1:0] uv, lim, msat;

   assign ma = (op == brf_pkg::OP_TOLMUL) ? W'(opa) : magf(opa);
   assign mb = magf(opb);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brf_pkg::AS_IDLE: begin
            if (start) begin
               if (op != brf_pkg::OP_DIV) begin
                  state_in = brf_pkg::AS_MUL;
               end else if (opb == '0) begin
                  state_in = brf_pkg::AS_SAT;
               end else begin
                  state_in = brf_pkg::AS_DIV;
               end
            end
         end
         brf_pkg::AS_MUL, brf_pkg::AS_DIV: begin
            if (cnt_ff == CW'(1)) state_in = brf_pkg::AS_SAT;
         end
         brf_pkg::AS_SAT: state_in = brf_pkg::AS_IDLE;
         default: state_in = brf_pkg::AS_IDLE;
      endcase
   end

   // Step arithmetic
   assign sum = prod_ff[2*W:W] + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   assign r2  = {rem_ff[W-1:0], num_ff[NW-1]};

   always_comb begin
      if (div_ff) begin
         uv = SW'(num_ff);
      end else if (tol_ff) begin
         uv = SW'(prod_ff[2*W-1:0] >> brf_pkg::TOL_SHIFT);
      end else begin
         uv = SW'(prod_ff[2*W-1:0] >> FRAC_BITS);
      end
      lim  = neg_ff ? NEG_LIM : POS_LIM;
      msat = (uv > lim) ? lim : uv;
   end

   // Datapath
   always_comb begin
      cnt_in   = cnt_ff;
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      rem_in   = rem_ff;
      num_in   = num_ff;
      dvsr_in  = dvsr_ff;
      neg_in   = neg_ff;
      tol_in   = tol_ff;
      div_in   = div_ff;
      res_in   = res_ff;
      done_in  = 1'b0;
      case (state_ff)
         brf_pkg::AS_IDLE: begin
            if (start) begin
               tol_in   = (op == brf_pkg::OP_TOLMUL);
               div_in   = (op == brf_pkg::OP_DIV);
               neg_in   = (op == brf_pkg::OP_TOLMUL) ? 1'b0 : (opa[W-1] ^ opb[W-1]);
               prod_in  = {(W+1)'(0), mb};
               mcand_in = ma;
               rem_in   = '0;
               dvsr_in  = mb;
               if (op == brf_pkg::OP_DIV) begin
                  cnt_in = CW'(NW);
                  if (opb == '0) begin
                     num_in = (opa == '0) ? '0 : '1;
                  end else begin
                     num_in = NW'(ma) << FRAC_BITS;
                  end
               end else begin
                  cnt_in = CW'(W);
               end
            end
         end
         brf_pkg::AS_MUL: begin
            prod_in = {1'b0, sum, prod_ff[W-1:1]};
            cnt_in  = cnt_ff - CW'(1);
         end
         brf_pkg::AS_DIV: begin
            if (r2 >= {1'b0, dvsr_ff}) begin
               rem_in = r2 - {1'b0, dvsr_ff};
               num_in = {num_ff[NW-2:0], 1'b1};
            end else begin
               rem_in = r2;
               num_in = {num_ff[NW-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CW'(1);
         end
         brf_pkg::AS_SAT: begin
            res_in  = neg_ff ? -signed'(msat[W-1:0]) : signed'(msat[W-1:0]);
            done_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brf_pkg::AS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
      rem_ff   <= rem_in;
      num_ff   <= num_in;
      dvsr_ff  <= dvsr_in;
      neg_ff   <= neg_in;
      tol_ff   <= tol_in;
      div_ff   <= div_in;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
`default_nettype wire

// File: rtl/core/bracketed_root_finder.sv
// Start items, the first reply and replies while idle give their result in the next cycle.
// A probe reply passes through a swap step, then multiplies and divides on one shared unit
// for a secant, inverse-quadratic or bisection step at Q16.16; one item is in work at a time.
// Synchronous active-high reset returns to idle with tolerances abs_tol=1, rel_tol=0.
`default_nettype none
module bracketed_root_finder #(
   parameter int VALUE_WIDTH = brf_pkg::VALUE_WIDTH_DEF,
   parameter int FRAC_BITS   = brf_pkg::FRAC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_mode,
   input  wire logic signed [brf_pkg::IO_WIDTH-1:0] req_first_end,
   input  wire logic signed [brf_pkg::IO_WIDTH-1:0] req_second_end,
   input  wire logic signed [brf_pkg::IO_WIDTH-1:0] req_fvalue,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_kind,
   output logic signed [brf_pkg::IO_WIDTH-1:0]    rsp_point,
   output logic signed [brf_pkg::IO_WIDTH-1:0]    rsp_other_end,
   output logic                                   rsp_bracketed,
   input  wire logic                              csr_wr_en,
   input  wire logic                              csr_index,
   input  wire logic [brf_pkg::ABS_TOL_WIDTH-1:0] csr_wdata
);

   localparam int W  = VALUE_WIDTH;
   localparam int IW = brf_pkg::IO_WIDTH;
   localparam int XW = (W > IW) ? W : IW;
   localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

   function automatic logic signed [W-1:0] addsat(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} + {y[W-1], y};
      if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
      return signed'(s[W-1:0]);
   endfunction

   function automatic logic signed [W-1:0] subsat(input logic signed [W-1:0] x,
                                                  input logic signed [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} - {y[W-1], y};
      if (s[W] != s[W-1]) return s[W] ? VMIN : VMAX;
      return signed'(s[W-1:0]);
   endfunction

   function automatic logic signed [W-1:0] negsat(input logic signed [W-1:0] x);
      return (x == VMIN) ? VMAX : -x;
   endfunction

   function automatic logic [W-1:0] magf(input logic signed [W-1:0] x);
      return x[W-1] ? W'(-x) : W'(x);
   endfunction

   function automatic logic signed [W-1:0] sat_in(input logic signed [IW-1:0] v);
      logic signed [XW-1:0] e;
      e = XW'(v);
      if (e > XW'(VMAX)) return VMAX;
      if (e < XW'(VMIN)) return VMIN;
      return e[W-1:0];
   endfunction

   function automatic logic signed [IW-1:0] to_out(input logic signed [W-1:0] x);
      logic signed [XW-1:0] e;
      e = XW'(x);
      return e[IW-1:0];
   endfunction

   brf_pkg::brf_state_type state_ff, state_in;

   logic [brf_pkg::ABS_TOL_WIDTH-1:0] abs_ff, abs_in;
   logic [brf_pkg::REL_TOL_WIDTH-1:0] rel_ff, rel_in;

   logic signed [W-1:0] pa_ff, pa_in, va_ff, va_in, pb_ff, pb_in, vb_ff, vb_in;
   logic signed [W-1:0] pc_ff, pc_in, vc_ff, vc_in, pd_ff, pd_in, vd_ff, vd_in;
   logic signed [W-1:0] tol_ff, tol_in, mb_ff, mb_in, p_ff, p_in, q_ff, q_in;
   logic signed [W-1:0] fdb_ff, fdb_in, fda_ff, fda_in, t_ff, t_in, w_ff, w_in;
   logic [1:0]          ic_ff, ic_in;
   logic                lwb_ff, lwb_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_kind_ff, rsp_kind_in;
   logic signed [IW-1:0] rsp_point_ff, rsp_point_in, rsp_other_ff, rsp_other_in;
   logic                rsp_br_ff, rsp_br_in;

   logic                alu_start, alu_done;
   brf_pkg::brf_op_type alu_op;
   logic signed [W-1:0] alu_a, alu_b, alu_res;

   logic                waiting, acc, far;
   logic signed [W-1:0] fv, abs_clamp, mid;
   logic [W:0]          msum;
   logic [XW-1:0]       abs_ext;

   assign waiting = (state_ff inside {brf_pkg::ST_IDLE, brf_pkg::ST_WAIT_FIRST,
                                      brf_pkg::ST_WAIT_SECOND, brf_pkg::ST_WAIT_PROBE});
   assign acc = req_valid && req_ready;
   assign fv  = sat_in(req_fvalue);
   assign far = magf(mb_ff) > $unsigned(tol_ff);

   // Absolute tolerance clamped to the value range
   assign abs_ext   = XW'(abs_ff);
   assign abs_clamp = (abs_ext > $unsigned(XW'(VMAX))) ? VMAX : signed'(abs_ext[W-1:0]);

   // Floor of (c+b)/2 without overflow
   assign msum = (W+1)'(pc_ff >>> 1) + (W+1)'(pb_ff >>> 1) + (W+1)'(pc_ff[0] & pb_ff[0]);
   assign mid  = signed'(msum[W-1:0]);

   brf_alu #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_alu (
      .clock  (clock),
      .reset  (reset),
      .start  (alu_start),
      .op     (alu_op),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         brf_pkg::ST_IDLE, brf_pkg::ST_WAIT_FIRST,
         brf_pkg::ST_WAIT_SECOND, brf_pkg::ST_WAIT_PROBE: begin
            if (acc) begin
               if (!req_mode) begin
                  state_in = brf_pkg::ST_WAIT_FIRST;
               end else if (state_ff == brf_pkg::ST_WAIT_FIRST) begin
                  state_in = brf_pkg::ST_WAIT_SECOND;
               end else if (state_ff != brf_pkg::ST_IDLE) begin
                  state_in = brf_pkg::ST_SWAP;
               end
            end
         end
         brf_pkg::ST_SWAP:   state_in = brf_pkg::ST_TOL_GO;
         brf_pkg::ST_TOL_GO: state_in = brf_pkg::ST_TOL_WAIT;
         brf_pkg::ST_TOL_WAIT: if (alu_done) state_in = brf_pkg::ST_TEST;
         brf_pkg::ST_TEST: begin
            if (!far) begin
               state_in = brf_pkg::ST_IDLE;
            end else if (ic_ff > 2'd2) begin
               state_in = brf_pkg::ST_UPDATE;
            end else begin
               state_in = brf_pkg::ST_P_GO;
            end
         end
         brf_pkg::ST_P_GO: state_in = brf_pkg::ST_P_WAIT;
         brf_pkg::ST_P_WAIT: begin
            if (alu_done) begin
               state_in = (ic_ff <= 2'd1) ? brf_pkg::ST_SIGN : brf_pkg::ST_FDB_GO;
            end
         end
         brf_pkg::ST_FDB_GO:   state_in = brf_pkg::ST_FDB_WAIT;
         brf_pkg::ST_FDB_WAIT: if (alu_done) state_in = brf_pkg::ST_FDA_GO;
         brf_pkg::ST_FDA_GO:   state_in = brf_pkg::ST_FDA_WAIT;
         brf_pkg::ST_FDA_WAIT: if (alu_done) state_in = brf_pkg::ST_PF_GO;
         brf_pkg::ST_PF_GO:    state_in = brf_pkg::ST_PF_WAIT;
         brf_pkg::ST_PF_WAIT:  if (alu_done) state_in = brf_pkg::ST_T1_GO;
         brf_pkg::ST_T1_GO:    state_in = brf_pkg::ST_T1_WAIT;
         brf_pkg::ST_T1_WAIT:  if (alu_done) state_in = brf_pkg::ST_T2_GO;
         brf_pkg::ST_T2_GO:    state_in = brf_pkg::ST_T2_WAIT;
         brf_pkg::ST_T2_WAIT:  if (alu_done) state_in = brf_pkg::ST_SIGN;
         brf_pkg::ST_SIGN:     state_in = brf_pkg::ST_QT_GO;
         brf_pkg::ST_QT_GO:    state_in = brf_pkg::ST_QT_WAIT;
         brf_pkg::ST_QT_WAIT: begin
            if (alu_done) begin
               if (p_ff == '0 || p_ff <= alu_res) begin
                  state_in = brf_pkg::ST_UPDATE;
               end else begin
                  state_in = brf_pkg::ST_MQ_GO;
               end
            end
         end
         brf_pkg::ST_MQ_GO: state_in = brf_pkg::ST_MQ_WAIT;
         brf_pkg::ST_MQ_WAIT: begin
            if (alu_done) begin
               state_in = (p_ff < alu_res) ? brf_pkg::ST_DIV_GO : brf_pkg::ST_UPDATE;
            end
         end
         brf_pkg::ST_DIV_GO:   state_in = brf_pkg::ST_DIV_WAIT;
         brf_pkg::ST_DIV_WAIT: if (alu_done) state_in = brf_pkg::ST_UPDATE;
         brf_pkg::ST_UPDATE:   state_in = brf_pkg::ST_WAIT_PROBE;
         default:              state_in = brf_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshake and shared unit operands
   always_comb begin
      req_ready = waiting && (!rsp_valid_ff || rsp_ready);
      alu_start = 1'b0;
      alu_op    = brf_pkg::OP_MUL;
      alu_a     = p_ff;
      alu_b     = q_ff;
      case (state_ff)
         brf_pkg::ST_TOL_GO: begin
            alu_start = 1'b1;
            alu_op    = brf_pkg::OP_TOLMUL;
            alu_a     = signed'(W'(rel_ff));
            alu_b     = pb_ff;
         end
         brf_pkg::ST_P_GO: begin
            alu_start = 1'b1;
            alu_a     = subsat(pb_ff, pa_ff);
            alu_b     = vb_ff;
         end
         brf_pkg::ST_FDB_GO: begin
            alu_start = 1'b1;
            alu_op    = brf_pkg::OP_DIV;
            alu_a     = subsat(vd_ff, vb_ff);
            alu_b     = subsat(pd_ff, pb_ff);
         end
         brf_pkg::ST_FDA_GO: begin
            alu_start = 1'b1;
            alu_op    = brf_pkg::OP_DIV;
            alu_a     = subsat(vd_ff, va_ff);
            alu_b     = subsat(pd_ff, pa_ff);
         end
         brf_pkg::ST_PF_GO: begin
            alu_start = 1'b1;
            alu_a     = p_ff;
            alu_b     = fda_ff;
         end
         brf_pkg::ST_T1_GO: begin
            alu_start = 1'b1;
            alu_a     = fdb_ff;
            alu_b     = va_ff;
         end
         brf_pkg::ST_T2_GO: begin
            alu_start = 1'b1;
            alu_a     = fda_ff;
            alu_b     = vb_ff;
         end
         brf_pkg::ST_QT_GO: begin
            alu_start = 1'b1;
            alu_a     = q_ff;
            alu_b     = tol_ff;
         end
         brf_pkg::ST_MQ_GO: begin
            alu_start = 1'b1;
            alu_a     = mb_ff;
            alu_b     = q_ff;
         end
         brf_pkg::ST_DIV_GO: begin
            alu_start = 1'b1;
            alu_op    = brf_pkg::OP_DIV;
         end
         default: ;
      endcase
   end

   // Datapath registers
   always_comb begin
      abs_in = abs_ff;  rel_in = rel_ff;
      pa_in = pa_ff;  va_in = va_ff;  pb_in = pb_ff;  vb_in = vb_ff;
      pc_in = pc_ff;  vc_in = vc_ff;  pd_in = pd_ff;  vd_in = vd_ff;
      tol_in = tol_ff;  mb_in = mb_ff;  p_in = p_ff;  q_in = q_ff;
      fdb_in = fdb_ff;  fda_in = fda_ff;  t_in = t_ff;  w_in = w_ff;
      ic_in = ic_ff;  lwb_in = lwb_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_point_in = rsp_point_ff;
      rsp_other_in = rsp_other_ff;
      rsp_br_in    = rsp_br_ff;

      // Configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            brf_pkg::CSR_ABS_TOL: abs_in = csr_wdata;
            brf_pkg::CSR_REL_TOL: rel_in = csr_wdata[brf_pkg::REL_TOL_WIDTH-1:0];
            default: ;
         endcase
      end

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         brf_pkg::ST_IDLE, brf_pkg::ST_WAIT_FIRST,
         brf_pkg::ST_WAIT_SECOND, brf_pkg::ST_WAIT_PROBE: begin
            if (acc) begin
               if (!req_mode) begin
                  pb_in  = sat_in(req_first_end);
                  pa_in  = sat_in(req_second_end);
                  ic_in  = 2'd0;
                  lwb_in = 1'b0;
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = brf_pkg::KIND_EVAL;
                  rsp_point_in = to_out(sat_in(req_first_end));
                  rsp_other_in = '0;
                  rsp_br_in    = 1'b0;
               end else begin
                  case (state_ff)
                     brf_pkg::ST_IDLE: begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = brf_pkg::KIND_IDLE;
                        rsp_point_in = '0;
                        rsp_other_in = '0;
                        rsp_br_in    = 1'b0;
                     end
                     brf_pkg::ST_WAIT_FIRST: begin
                        vb_in = fv;
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = brf_pkg::KIND_EVAL;
                        rsp_point_in = to_out(pa_ff);
                        rsp_other_in = '0;
                        rsp_br_in    = 1'b0;
                     end
                     brf_pkg::ST_WAIT_SECOND: begin
                        va_in = fv;
                        pc_in = pa_ff;
                        vc_in = fv;
                        ic_in = 2'd0;
                     end
                     default: begin
                        vb_in = fv;
                        if (!vc_ff[W-1] ? !fv[W-1] : (fv[W-1] || fv == '0)) begin
                           pc_in = pa_ff;
                           vc_in = va_ff;
                           ic_in = 2'd0;
                        end else if (lwb_ff) begin
                           ic_in = 2'd0;
                        end else if (ic_ff < 2'd3) begin
                           ic_in = ic_ff + 2'd1;
                        end
                     end
                  endcase
               end
            end
         end
         // Keep the smaller |f| in b
         brf_pkg::ST_SWAP: begin
            if (magf(vc_ff) < magf(vb_ff)) begin
               if (pc_ff != pa_ff) begin
                  pd_in = pa_ff;
                  vd_in = va_ff;
               end
               pa_in = pb_ff;  va_in = vb_ff;
               pb_in = pc_ff;  vb_in = vc_ff;
               pc_in = pb_ff;  vc_in = vb_ff;
            end
         end
         brf_pkg::ST_TOL_WAIT: begin
            if (alu_done) begin
               tol_in = addsat(abs_clamp, alu_res);
               mb_in  = subsat(mid, pb_ff);
            end
         end
         // Stop test, else pick the step kind
         brf_pkg::ST_TEST: begin
            if (!far) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = brf_pkg::KIND_DONE;
               rsp_point_in = to_out(pb_ff);
               rsp_other_in = to_out(pc_ff);
               rsp_br_in    = !vc_ff[W-1] ? (vb_ff[W-1] || vb_ff == '0) : !vb_ff[W-1];
            end else if (ic_ff > 2'd2) begin
               w_in = mb_ff;
            end else if (mb_ff == '0) begin
               tol_in = '0;
            end else if (mb_ff[W-1]) begin
               tol_in = -tol_ff;
            end
         end
         brf_pkg::ST_P_WAIT: begin
            if (alu_done) begin
               p_in = alu_res;
               if (ic_ff <= 2'd1) q_in = subsat(va_ff, vb_ff);
            end
         end
         brf_pkg::ST_FDB_WAIT: if (alu_done) fdb_in = alu_res;
         brf_pkg::ST_FDA_WAIT: if (alu_done) fda_in = alu_res;
         brf_pkg::ST_PF_WAIT:  if (alu_done) p_in = alu_res;
         brf_pkg::ST_T1_WAIT:  if (alu_done) t_in = alu_res;
         brf_pkg::ST_T2_WAIT:  if (alu_done) q_in = subsat(t_ff, alu_res);
         brf_pkg::ST_SIGN: begin
            if (p_ff[W-1]) begin
               p_in = negsat(p_ff);
               q_in = negsat(q_ff);
            end
         end
         brf_pkg::ST_QT_WAIT: begin
            if (alu_done && (p_ff == '0 || p_ff <= alu_res)) w_in = tol_ff;
         end
         brf_pkg::ST_MQ_WAIT: begin
            if (alu_done && !(p_ff < alu_res)) w_in = mb_ff;
         end
         brf_pkg::ST_DIV_WAIT: if (alu_done) w_in = alu_res;
         // Advance the bracket and ask for the next probe
         brf_pkg::ST_UPDATE: begin
            lwb_in = (w_ff == mb_ff);
            pd_in  = pa_ff;
            vd_in  = va_ff;
            pa_in  = pb_ff;
            va_in  = vb_ff;
            pb_in  = addsat(pb_ff, w_ff);
            rsp_valid_in = 1'b1;
            rsp_kind_in  = brf_pkg::KIND_EVAL;
            rsp_point_in = to_out(addsat(pb_ff, w_ff));
            rsp_other_in = '0;
            rsp_br_in    = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brf_pkg::ST_IDLE;
         abs_ff       <= brf_pkg::ABS_TOL_WIDTH'(1);
         rel_ff       <= '0;
         pa_ff        <= '0;
         va_ff        <= '0;
         pb_ff        <= '0;
         vb_ff        <= '0;
         pc_ff        <= '0;
         vc_ff        <= '0;
         ic_ff        <= 2'd0;
         lwb_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         abs_ff       <= abs_in;
         rel_ff       <= rel_in;
         pa_ff        <= pa_in;
         va_ff        <= va_in;
         pb_ff        <= pb_in;
         vb_ff        <= vb_in;
         pc_ff        <= pc_in;
         vc_ff        <= vc_in;
         ic_ff        <= ic_in;
         lwb_ff       <= lwb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pd_ff        <= pd_in;
      vd_ff        <= vd_in;
      tol_ff       <= tol_in;
      mb_ff        <= mb_in;
      p_ff         <= p_in;
      q_ff         <= q_in;
      fdb_ff       <= fdb_in;
      fda_ff       <= fda_in;
      t_ff         <= t_in;
      w_ff         <= w_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_point_ff <= rsp_point_in;
      rsp_other_ff <= rsp_other_in;
      rsp_br_ff    <= rsp_br_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_point     = rsp_point_ff;
   assign rsp_other_end = rsp_other_ff;
   assign rsp_bracketed = rsp_br_ff;

endmodule
`default_nettype wire

// File: rtl/core/brf_checker.sv
`default_nettype none
`include "bracketed_root_finder_assert.svh"
module brf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_kind,
   input wire logic [31:0] rsp_point,
   input wire logic [31:0] rsp_other_end,
   input wire logic        rsp_bracketed
);

   // A stalled result holds
   `BRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point))
   // No new item while a result is stuck
   `BRF_ASSERT_SAME(a_no_take, clock, reset, rsp_valid && !rsp_ready, !req_ready)
   // Only defined result kinds
   `BRF_ASSERT_SAME(a_kind, clock, reset, rsp_valid, rsp_kind != 2'd3)
   // Other end and sign flag only on a finished search
   `BRF_ASSERT_SAME(a_fields, clock, reset, rsp_valid && rsp_kind != brf_pkg::KIND_DONE, rsp_other_end == 32'd0 && !rsp_bracketed)

endmodule

bind bracketed_root_finder brf_checker u_brf_checker (.*);
`default_nettype wire
